/* rtl/core/preemptive_priority_scheduler_macros.svh */
// Assertion macros for the preemptive priority scheduler checker.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define PPSCH_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ppsch check failed: %m");

// Next-cycle implication, sampled on the rising clock edge.
`define PPSCH_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ppsch check failed: %m");

`endif

/* rtl/core/ppsch_pkg.sv */
// Shared constants and types for the preemptive priority scheduler.
// No dependencies; imported by ppsch_pick, the top scheduler module and the checker.
`default_nettype none

package ppsch_pkg;

  localparam int unsigned SLOTS_DEF     = 16;
  localparam int unsigned TIME_BITS_DEF = 16;
  localparam int unsigned PRIO_BITS_DEF = 8;

  localparam int unsigned ID_W      = 4;
  localparam int unsigned PRIO_IN_W = 8;
  localparam int unsigned BURST_W   = 16;
  localparam int unsigned TOUT_W    = 16;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 80;

  localparam int unsigned IN_SID_LSB   = 0;
  localparam int unsigned IN_PRIO_LSB  = 4;
  localparam int unsigned IN_BURST_LSB = 12;

  localparam int unsigned RES_REJ     = 0;
  localparam int unsigned RES_RAN_V   = 1;
  localparam int unsigned RES_RAN_ID  = 2;
  localparam int unsigned RES_DONE_V  = 6;
  localparam int unsigned RES_DONE_ID = 7;
  localparam int unsigned RES_COMP    = 11;
  localparam int unsigned RES_TAT     = 27;
  localparam int unsigned RES_WAIT    = 43;
  localparam int unsigned RES_RESP    = 59;

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef struct packed {
    logic clear;
    logic sample;
  } pick_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/ppsch_slot_ram.sv */
// Slot record memory: one write port and one read port with registered data.
// No dependencies.
`default_nettype none

module ppsch_slot_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/ppsch_pick.sv */
// Shared priority comparator that keeps the best ready slot over a scan.
// Depends on ppsch_pkg.
`default_nettype none

module ppsch_pick import ppsch_pkg::*; #(
  parameter int unsigned SLOTS     = SLOTS_DEF,
  parameter int unsigned PRIO_BITS = PRIO_BITS_DEF,
  localparam int unsigned SlotW = $clog2(SLOTS)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire pick_ctl_t            ctl_i,
  input  wire logic [SlotW-1:0]     idx_i,
  input  wire logic                 eligible_i,
  input  wire logic [PRIO_BITS-1:0] prio_i,
  output logic                      take_o,
  output logic                      found_o,
  output logic      [SlotW-1:0]     best_idx_o,
  output logic      [PRIO_BITS-1:0] best_prio_o
);

  logic                 found_q;
  logic [SlotW-1:0]     best_idx_q;
  logic [PRIO_BITS-1:0] best_prio_q;

  // A later slot wins only on a strictly higher priority, so ties stay low.
  assign take_o = ctl_i.sample && eligible_i && (!found_q || (prio_i > best_prio_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      best_idx_q  <= '0;
      best_prio_q <= '0;
    end else if (ctl_i.clear) begin
      found_q <= 1'b0;
    end else if (take_o) begin
      found_q     <= 1'b1;
      best_idx_q  <= idx_i;
      best_prio_q <= prio_i;
    end
  end

  assign found_o     = found_q;
  assign best_idx_o  = best_idx_q;
  assign best_prio_o = best_prio_q;

endmodule

`default_nettype wire

/* rtl/core/preemptive_priority_scheduler.sv */
// Preemptive priority scheduler over a table of process slots.
// Beats arrive on the s_axis channel and one result beat leaves on m_axis
// for every input beat. s_axis_tuser selects an arrival or a time tick.
// An arrival loads a free slot; it passes the ARRIVE and EMIT states,
// and its result is registered as the block returns to idle.
// A tick scans the slot table one slot per cycle through a single memory
// read port and a shared comparator, then retires, selects and runs a slot
// and advances time in the DECIDE state. Its result is then registered in
// the EMIT state as the block returns to idle.
// The block takes one beat at a time: s_axis_tready is high only while no
// beat is in work. A finished result waits in the output register while
// the next beat is accepted and worked on; if the receiver still stalls
// when that next result is ready, the block holds it and stays busy.
// Reset clears all slots, the running slot and the time counter. Slot
// records live in memory and are used only after an arrival wrote them,
// so no clearing pass is needed.
// Depends on ppsch_pkg, ppsch_slot_ram and ppsch_pick.
`default_nettype none

module preemptive_priority_scheduler import ppsch_pkg::*; #(
  parameter int unsigned SLOTS         = SLOTS_DEF,
  parameter int unsigned TIME_BITS     = TIME_BITS_DEF,
  parameter int unsigned PRIORITY_BITS = PRIO_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // slot_id[3:0], priority_req[11:4], burst_length[27:12], zero pad
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // op
  input  wire logic                  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // rejected, ran_valid, ran_id, done_valid, done_id, completion_time,
  // turnaround_time, wait_time, response_time, zero pad
  output logic      [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned SlotW = $clog2(SLOTS);
  localparam int unsigned CntW  = $clog2(SLOTS + 1);
  localparam int unsigned CmpW  = (TIME_BITS > BURST_W) ? TIME_BITS : BURST_W;

  localparam int unsigned RecRem   = 0;
  localparam int unsigned RecPrio  = RecRem + BURST_W;
  localparam int unsigned RecArr   = RecPrio + PRIORITY_BITS;
  localparam int unsigned RecBurst = RecArr + TIME_BITS;
  localparam int unsigned RecResp  = RecBurst + BURST_W;
  localparam int unsigned RecW     = RecResp + TIME_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARRIVE,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT
  } state_e;

  state_e                   state_q;
  logic [SLOTS-1:0]         active_q;
  logic [SLOTS-1:0]         started_q;
  logic [SlotW-1:0]         run_slot_q;
  logic                     run_valid_q;
  logic [TIME_BITS-1:0]     time_q;
  logic [CntW-1:0]          scan_cnt_q;
  logic                     smp_q;
  logic [SlotW-1:0]         smp_idx_q;

  logic [ID_W-1:0]          sid_q;
  logic [PRIO_IN_W-1:0]     prio_q;
  logic [BURST_W-1:0]       burst_q;

  logic [BURST_W-1:0]       run_rem_q;
  logic [PRIORITY_BITS-1:0] run_prio_q;
  logic [TIME_BITS-1:0]     run_arr_q;
  logic [BURST_W-1:0]       run_burst_q;
  logic [TIME_BITS-1:0]     run_resp_q;
  logic [BURST_W-1:0]       best_rem_q;
  logic [TIME_BITS-1:0]     best_arr_q;
  logic [BURST_W-1:0]       best_burst_q;
  logic [TIME_BITS-1:0]     best_resp_q;

  logic                     res_rej_q;
  logic                     res_ran_v_q;
  logic [ID_W-1:0]          res_ran_id_q;
  logic                     res_done_v_q;
  logic [ID_W-1:0]          res_done_id_q;
  logic [TOUT_W-1:0]        res_comp_q;
  logic [TIME_BITS-1:0]     tat_q;
  logic [TOUT_W-1:0]        res_resp_q;
  logic                     m_valid_q;
  logic [OUT_DATA_W-1:0]    m_data_q;

  logic                     in_accept;
  logic                     out_free;
  logic [SlotW-1:0]         sid_idx;
  logic                     sid_in_range;
  logic                     arr_rej;

  logic                     ram_we;
  logic [SlotW-1:0]         ram_waddr;
  logic [RecW-1:0]          ram_wdata;
  logic                     ram_re;
  logic [RecW-1:0]          ram_rdata;
  logic [BURST_W-1:0]       rd_rem;
  logic [PRIORITY_BITS-1:0] rd_prio;
  logic [TIME_BITS-1:0]     rd_arr;
  logic [BURST_W-1:0]       rd_burst;
  logic [TIME_BITS-1:0]     rd_resp;

  pick_ctl_t                pick_ctl;
  logic                     pick_elig;
  logic                     pick_take;
  logic                     pick_found;
  logic [SlotW-1:0]         pick_idx;
  logic [PRIORITY_BITS-1:0] pick_prio;

  logic                     retire;
  logic                     run_ok;
  logic                     use_run;
  logic                     sel_valid;
  logic [SlotW-1:0]         sel_idx;
  logic [BURST_W-1:0]       sel_rem;
  logic [PRIORITY_BITS-1:0] sel_prio;
  logic [TIME_BITS-1:0]     sel_arr;
  logic [BURST_W-1:0]       sel_burst;
  logic [TIME_BITS-1:0]     sel_resp_d;
  logic [TIME_BITS-1:0]     tat_d;
  logic [TIME_BITS-1:0]     time_d;
  logic [CmpW-1:0]          tat_ext;
  logic [CmpW-1:0]          burst_ext;
  logic [TOUT_W-1:0]        wait_d;
  logic [OUT_DATA_W-1:0]    out_data;

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_free      = !m_valid_q || m_axis_tready;

  assign sid_idx      = SlotW'(sid_q);
  assign sid_in_range = (32'(sid_q) < 32'(SLOTS));
  assign arr_rej      = !sid_in_range || active_q[sid_idx] || (burst_q == '0);

  assign rd_rem   = ram_rdata[RecRem +: BURST_W];
  assign rd_prio  = ram_rdata[RecPrio +: PRIORITY_BITS];
  assign rd_arr   = ram_rdata[RecArr +: TIME_BITS];
  assign rd_burst = ram_rdata[RecBurst +: BURST_W];
  assign rd_resp  = ram_rdata[RecResp +: TIME_BITS];

  assign pick_ctl.clear  = in_accept && (s_axis_tuser == OP_TICK);
  assign pick_ctl.sample = (state_q == ST_SCAN) && smp_q;
  assign pick_elig       = active_q[smp_idx_q] && (rd_rem != '0);

  assign retire    = run_valid_q && active_q[run_slot_q] && (run_rem_q == '0);
  assign run_ok    = run_valid_q && active_q[run_slot_q] && (run_rem_q != '0);
  assign use_run   = run_ok && (!pick_found || (pick_prio <= run_prio_q));
  assign sel_valid = use_run || pick_found;
  assign sel_idx   = use_run ? run_slot_q  : pick_idx;
  assign sel_rem   = use_run ? run_rem_q   : best_rem_q;
  assign sel_prio  = use_run ? run_prio_q  : pick_prio;
  assign sel_arr   = use_run ? run_arr_q   : best_arr_q;
  assign sel_burst = use_run ? run_burst_q : best_burst_q;

  always_comb begin
    if (started_q[sel_idx]) begin
      sel_resp_d = use_run ? run_resp_q : best_resp_q;
    end else begin
      sel_resp_d = time_q - sel_arr;
    end
  end

  assign tat_d  = time_q - run_arr_q;
  assign time_d = (time_q == '1) ? time_q : time_q + 1'b1;

  assign tat_ext   = CmpW'(tat_q);
  assign burst_ext = CmpW'(run_burst_q);
  always_comb begin
    if (res_done_v_q && (tat_ext > burst_ext)) begin
      wait_d = TOUT_W'(tat_ext - burst_ext);
    end else begin
      wait_d = '0;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sel_idx;
    ram_wdata = {sel_resp_d, sel_burst, sel_arr, sel_prio, sel_rem - 1'b1};
    if (state_q == ST_ARRIVE) begin
      ram_we    = !arr_rej;
      ram_waddr = sid_idx;
      ram_wdata = {{TIME_BITS{1'b0}}, burst_q, time_q, PRIORITY_BITS'(prio_q), burst_q};
    end else if (state_q == ST_DECIDE) begin
      ram_we = sel_valid;
    end
  end

  assign ram_re = (state_q == ST_SCAN) && (scan_cnt_q < CntW'(SLOTS));

  always_comb begin
    out_data                            = '0;
    out_data[RES_REJ]                   = res_rej_q;
    out_data[RES_RAN_V]                 = res_ran_v_q;
    out_data[RES_RAN_ID +: ID_W]        = res_ran_id_q;
    out_data[RES_DONE_V]                = res_done_v_q;
    out_data[RES_DONE_ID +: ID_W]       = res_done_id_q;
    out_data[RES_COMP +: TOUT_W]        = res_comp_q;
    out_data[RES_TAT +: TOUT_W]         = TOUT_W'(tat_q);
    out_data[RES_WAIT +: TOUT_W]        = wait_d;
    out_data[RES_RESP +: TOUT_W]        = res_resp_q;
  end

  ppsch_slot_ram #(
    .WIDTH (RecW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (scan_cnt_q[SlotW-1:0]),
    .rdata_o (ram_rdata)
  );

  ppsch_pick #(
    .SLOTS     (SLOTS),
    .PRIO_BITS (PRIORITY_BITS)
  ) u_pick (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (pick_ctl),
    .idx_i       (smp_idx_q),
    .eligible_i  (pick_elig),
    .prio_i      (rd_prio),
    .take_o      (pick_take),
    .found_o     (pick_found),
    .best_idx_o  (pick_idx),
    .best_prio_o (pick_prio)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= '0;
      started_q   <= '0;
      run_slot_q  <= '0;
      run_valid_q <= 1'b0;
      time_q      <= '0;
      scan_cnt_q  <= '0;
      smp_q       <= 1'b0;
      smp_idx_q   <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      if ((state_q == ST_EMIT) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            scan_cnt_q <= '0;
            smp_q      <= 1'b0;
            if (s_axis_tuser == OP_ARRIVE) begin
              state_q <= ST_ARRIVE;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_ARRIVE: begin
          if (!arr_rej) begin
            active_q[sid_idx]  <= 1'b1;
            started_q[sid_idx] <= 1'b0;
          end
          state_q <= ST_EMIT;
        end
        ST_SCAN: begin
          smp_q     <= (scan_cnt_q < CntW'(SLOTS));
          smp_idx_q <= scan_cnt_q[SlotW-1:0];
          if (scan_cnt_q < CntW'(SLOTS)) begin
            scan_cnt_q <= scan_cnt_q + 1'b1;
          end else begin
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (retire) begin
            active_q[run_slot_q] <= 1'b0;
          end
          if (sel_valid) begin
            started_q[sel_idx] <= 1'b1;
            run_slot_q         <= sel_idx;
          end
          run_valid_q <= sel_valid;
          time_q      <= time_d;
          state_q     <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sid_q   <= s_axis_tdata[IN_SID_LSB +: ID_W];
      prio_q  <= s_axis_tdata[IN_PRIO_LSB +: PRIO_IN_W];
      burst_q <= s_axis_tdata[IN_BURST_LSB +: BURST_W];
    end
    if ((state_q == ST_SCAN) && smp_q && (smp_idx_q == run_slot_q)) begin
      run_rem_q   <= rd_rem;
      run_prio_q  <= rd_prio;
      run_arr_q   <= rd_arr;
      run_burst_q <= rd_burst;
      run_resp_q  <= rd_resp;
    end
    if (pick_take) begin
      best_rem_q   <= rd_rem;
      best_arr_q   <= rd_arr;
      best_burst_q <= rd_burst;
      best_resp_q  <= rd_resp;
    end
    if (state_q == ST_ARRIVE) begin
      res_rej_q     <= arr_rej;
      res_ran_v_q   <= 1'b0;
      res_ran_id_q  <= '0;
      res_done_v_q  <= 1'b0;
      res_done_id_q <= '0;
      res_comp_q    <= '0;
      tat_q         <= '0;
      res_resp_q    <= '0;
    end
    if (state_q == ST_DECIDE) begin
      res_rej_q     <= 1'b0;
      res_ran_v_q   <= sel_valid;
      res_ran_id_q  <= sel_valid ? ID_W'(sel_idx) : '0;
      res_done_v_q  <= retire;
      res_done_id_q <= retire ? ID_W'(run_slot_q) : '0;
      res_comp_q    <= retire ? TOUT_W'(time_q) : '0;
      tat_q         <= retire ? tat_d : '0;
      res_resp_q    <= retire ? TOUT_W'(run_resp_q) : '0;
    end
    if ((state_q == ST_EMIT) && out_free) begin
      m_data_q <= out_data;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

/* rtl/core/ppsch_checker.sv */
// Port-level checker for the preemptive priority scheduler, bound to the top.
// Depends on ppsch_pkg and preemptive_priority_scheduler_macros.svh.
`default_nettype none

`include "preemptive_priority_scheduler_macros.svh"

module ppsch_checker import ppsch_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  input wire logic                  s_axis_tuser,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic              rej;
  logic              ran_v;
  logic              done_v;
  logic [TOUT_W-1:0] comp;
  logic [TOUT_W-1:0] tat;
  logic [TOUT_W-1:0] wt;
  logic [TOUT_W-1:0] resp;
  logic              in_beat;
  logic              out_wait;
  logic              times_zero;

  assign rej        = m_axis_tdata[RES_REJ];
  assign ran_v      = m_axis_tdata[RES_RAN_V];
  assign done_v     = m_axis_tdata[RES_DONE_V];
  assign comp       = m_axis_tdata[RES_COMP +: TOUT_W];
  assign tat        = m_axis_tdata[RES_TAT +: TOUT_W];
  assign wt         = m_axis_tdata[RES_WAIT +: TOUT_W];
  assign resp       = m_axis_tdata[RES_RESP +: TOUT_W];
  assign in_beat    = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_ARRIVE || 1'b1);
  assign out_wait   = m_axis_tvalid && !m_axis_tready;
  assign times_zero = (comp == '0) && (tat == '0) && (wt == '0) && (resp == '0);

  `PPSCH_ASSERT_NXT(a_out_hold, out_wait, m_axis_tvalid && $stable(m_axis_tdata))
  `PPSCH_ASSERT_NXT(a_one_at_a_time, in_beat, !s_axis_tready)
  `PPSCH_ASSERT_IMP(a_reject_alone, m_axis_tvalid && rej, !ran_v && !done_v)
  `PPSCH_ASSERT_IMP(a_idle_times_zero, m_axis_tvalid && !done_v, times_zero)
  `PPSCH_ASSERT_IMP(a_wait_bounded, m_axis_tvalid && done_v, wt <= tat && resp <= tat)

endmodule

bind preemptive_priority_scheduler ppsch_checker u_ppsch_checker (.*);

`default_nettype wire
